// ----- src/htfr_pkg.sv -----
// types, constants and byte count helpers for the header/tail frame receiver
`timescale 1ns / 1ps

package htfr_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_FIRST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_SECOND   = 3'd3;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'hAA;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h55;
  localparam logic [7:0] TAIL_FIRST_RST    = 8'h0D;
  localparam logic [7:0] TAIL_SECOND_RST   = 8'h0A;

  localparam logic [7:0] MODE_MASK = 8'h79;

  // frame positions that are ever read back
  localparam int POS_LEN   = 2;
  localparam int POS_MODE  = 3;
  localparam int POS_SURGE = 5;
  localparam int POS_SWAY  = 9;
  localparam int POS_YAW   = 13;
  localparam int POS_FIRST = 2;
  localparam int POS_LAST  = 16;

  localparam int NUM_WORDS = 3;

  typedef enum logic [1:0] {
    ST_HEADER1,
    ST_HEADER2,
    ST_BODY,
    ST_TAIL1
  } hunt_state_e;

  typedef struct packed {
    logic [31:0] surge_word;
    logic [31:0] sway_word;
    logic [31:0] yaw_word;
    logic [7:0]  length_field;
    logic        command_ok;
  } result_t;

  // min(len/3, 4)
  function automatic logic [2:0] surge_count(logic [7:0] len);
    logic [2:0] cnt;
    if (len < 8'd3) cnt = 3'd0;
    else if (len < 8'd6) cnt = 3'd1;
    else if (len < 8'd9) cnt = 3'd2;
    else if (len < 8'd12) cnt = 3'd3;
    else cnt = 3'd4;
    return cnt;
  endfunction

  // 2*(len/3) - 4 clamped to 0..4
  function automatic logic [2:0] sway_count(logic [7:0] len);
    logic [2:0] cnt;
    if (len < 8'd9) cnt = 3'd0;
    else if (len < 8'd12) cnt = 3'd2;
    else cnt = 3'd4;
    return cnt;
  endfunction

  // len - 8 clamped to 0..4
  function automatic logic [2:0] yaw_count(logic [7:0] len);
    logic [7:0] diff;
    logic [2:0] cnt;
    diff = len - 8'd8;
    if (len < 8'd9) cnt = 3'd0;
    else if (len < 8'd12) cnt = diff[2:0];
    else cnt = 3'd4;
    return cnt;
  endfunction

endpackage

// ----- src/header_tail_frame_receiver.sv -----
// A result is registered on the closing tail byte. Throughput: one received byte
// per cycle when not stalled; the frame positions that are read back sit in fixed
// byte registers with the current byte forwarded, so a frame closes in the same
// cycle as its last byte. An output register plus a skid stage keep input
// transfers going while a result waits. Reset (rst_ni, async, active low) restores
// the sync/tail registers, clears the held words and restarts the hunt.
`timescale 1ns / 1ps

module header_tail_frame_receiver #(
  parameter int FRAME_DEPTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [htfr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [31:0]                    surge_word_o,
  output logic [31:0]                    sway_word_o,
  output logic [31:0]                    yaw_word_o,
  output logic [7:0]                     length_field_o,
  output logic                           command_ok_o
);
  import htfr_pkg::*;

  localparam int IDX_W = $clog2(FRAME_DEPTH);

  logic [7:0] header_first_q, header_second_q, tail_first_q, tail_second_q;

  hunt_state_e      state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       frame_q [POS_FIRST:POS_LAST];
  logic [7:0]       fwd     [POS_FIRST:POS_LAST];
  logic [31:0]      held_q  [NUM_WORDS];
  logic [31:0]      held_d  [NUM_WORDS];
  logic [2:0]       cnt     [NUM_WORDS];

  logic    in_xfer, out_xfer;
  logic    restart, complete, mode_ok;
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, res;

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_xfer   = out_valid_q & ~out_stall_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_first_q  <= HEADER_FIRST_RST;
      header_second_q <= HEADER_SECOND_RST;
      tail_first_q    <= TAIL_FIRST_RST;
      tail_second_q   <= TAIL_SECOND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HEADER_FIRST:  header_first_q  <= cfg_data_i;
        REG_HEADER_SECOND: header_second_q <= cfg_data_i;
        REG_TAIL_FIRST:    tail_first_q    <= cfg_data_i;
        REG_TAIL_SECOND:   tail_second_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // current byte forwarded into the store view
  always_comb begin
    for (int p = POS_FIRST; p <= POS_LAST; p++) begin
      fwd[p] = (idx_q == IDX_W'(p)) ? rx_byte_i : frame_q[p];
    end
  end

  // hunt state machine
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    restart  = 1'b0;
    complete = 1'b0;
    unique case (state_q)
      ST_HEADER1: begin
        if (rx_byte_i == header_first_q) begin
          state_d = ST_HEADER2;
          idx_d   = IDX_W'(1);
        end else begin
          idx_d = '0;
        end
      end
      ST_HEADER2: begin
        if (rx_byte_i == header_second_q) begin
          state_d = ST_BODY;
          idx_d   = IDX_W'(2);
        end else begin
          state_d = ST_HEADER1;
          idx_d   = '0;
        end
      end
      ST_BODY, ST_TAIL1: begin
        if (state_q == ST_TAIL1 && rx_byte_i == tail_second_q) begin
          complete = 1'b1;
          restart  = 1'b1;
        end else begin
          state_d = (rx_byte_i == tail_first_q && state_q == ST_BODY) ? ST_TAIL1 : ST_BODY;
          idx_d   = idx_q + IDX_W'(1);
          if (idx_q == IDX_W'(FRAME_DEPTH - 1)) begin
            restart = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (restart) begin
      state_d = ST_HEADER1;
      idx_d   = '0;
    end
  end

  // word update on a completed frame
  assign mode_ok = (fwd[POS_MODE] & MODE_MASK) == MODE_MASK;
  assign cnt[0]  = surge_count(fwd[POS_LEN]);
  assign cnt[1]  = sway_count(fwd[POS_LEN]);
  assign cnt[2]  = yaw_count(fwd[POS_LEN]);

  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      held_d[w] = held_q[w];
      for (int k = 0; k < 4; k++) begin
        if (mode_ok && 3'(k) < cnt[w]) begin
          unique case (w)
            0:       held_d[w][8*k +: 8] = fwd[POS_SURGE + k];
            1:       held_d[w][8*k +: 8] = fwd[POS_SWAY + k];
            default: held_d[w][8*k +: 8] = fwd[POS_YAW + k];
          endcase
        end
      end
    end
  end

  assign res.surge_word   = held_d[0];
  assign res.sway_word    = held_d[1];
  assign res.yaw_word     = held_d[2];
  assign res.length_field = fwd[POS_LEN];
  assign res.command_ok   = mode_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEADER1;
      idx_q   <= '0;
      for (int p = POS_FIRST; p <= POS_LAST; p++) frame_q[p] <= '0;
      for (int w = 0; w < NUM_WORDS; w++) held_q[w] <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
      idx_q   <= idx_d;
      for (int p = POS_FIRST; p <= POS_LAST; p++) begin
        if (restart) frame_q[p] <= '0;
        else if (idx_q == IDX_W'(p)) frame_q[p] <= rx_byte_i;
      end
      if (complete) begin
        for (int w = 0; w < NUM_WORDS; w++) held_q[w] <= held_d[w];
      end
    end
  end

  // output register and skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_xfer && complete) begin
        if (!out_valid_q || out_xfer) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= skid_valid_q;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_xfer) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && complete) begin
      if (!out_valid_q || out_xfer) begin
        if (skid_valid_q) begin
          out_q  <= skid_q;
          skid_q <= res;
        end else begin
          out_q <= res;
        end
      end else begin
        skid_q <= res;
      end
    end else if (out_xfer && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign surge_word_o   = out_q.surge_word;
  assign sway_word_o    = out_q.sway_word;
  assign yaw_word_o     = out_q.yaw_word;
  assign length_field_o = out_q.length_field;
  assign command_ok_o   = out_q.command_ok;

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  a_hunt_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HEADER1 |-> idx_q == '0)
    else $error("byte index not zero while hunting the first header byte");

  a_hunt_store_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HEADER1 || state_q == ST_HEADER2) |->
      (frame_q[POS_LEN] == '0 && frame_q[POS_MODE] == '0))
    else $error("frame store not cleared outside a frame body");

  a_result_from_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_TAIL1)
    else $error("result produced without a preceding tail byte");

endmodule

// ----- verif/htfr_frame_checker.sv -----
// channel monitor, frame result predictor and comparator for the header/tail frame receiver
`timescale 1ns / 1ps

module htfr_frame_checker #(
  parameter int STORE_DEPTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [htfr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                     cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [31:0]                    surge_word_i,
  input  logic [31:0]                    sway_word_i,
  input  logic [31:0]                    yaw_word_i,
  input  logic [7:0]                     length_field_i,
  input  logic                           command_ok_i,
  output int                             pending_o,
  output int                             fail_count_o
);

  import htfr_pkg::*;

  localparam int W_SURGE = 0;
  localparam int W_SWAY  = 1;
  localparam int W_YAW   = 2;
  localparam int IDX_W   = $clog2(STORE_DEPTH);
  localparam int FILL_W  = IDX_W + 1;
  localparam int WORD_W  = $clog2(NUM_WORDS);

  logic [7:0]                     sync_a;
  logic [7:0]                     sync_b;
  logic [7:0]                     end_a;
  logic [7:0]                     end_b;
  hunt_state_e                    hunt;
  logic [FILL_W-1:0]              fill;
  logic [7:0]                     frame_buf [STORE_DEPTH];
  logic [31:0]                    held [NUM_WORDS];
  result_t                        frames_due [$];
  int                             fails;

  function automatic int clip_count(input int n);
    return (n < 0) ? 0 : ((n > 4) ? 4 : n);
  endfunction

  task automatic drop_frame();
    foreach (frame_buf[k]) frame_buf[k] = 8'h00;
    hunt = ST_HEADER1;
    fill = '0;
  endtask

  task automatic patch_word(input int w, input int pos, input int cnt);
    for (int k = 0; k < cnt; k++) begin
      held[WORD_W'(w)][8*k +: 8] = frame_buf[IDX_W'(pos + k)];
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    result_t due;
    int      len;
    bit      advance;
    advance = 1'b0;
    if (fill < STORE_DEPTH) frame_buf[fill[IDX_W-1:0]] = b;
    case (hunt)
      ST_HEADER1: begin
        if (b == sync_a) begin
          hunt = ST_HEADER2;
          fill = FILL_W'(1);
        end else begin
          fill = '0;
        end
      end
      ST_HEADER2: begin
        if (b == sync_b) begin
          hunt = ST_BODY;
          fill = FILL_W'(2);
        end else begin
          hunt = ST_HEADER1;
          fill = '0;
        end
      end
      ST_BODY: begin
        if (b == end_a) hunt = ST_TAIL1;
        advance = 1'b1;
      end
      default: begin
        if (b == end_b) begin
          len = int'(frame_buf[POS_LEN]);
          due.command_ok = ((frame_buf[POS_MODE] & MODE_MASK) == MODE_MASK);
          if (due.command_ok) begin
            patch_word(W_SURGE, POS_SURGE, clip_count(len / 3));
            patch_word(W_SWAY, POS_SWAY, clip_count(2 * (len / 3) - 4));
            patch_word(W_YAW, POS_YAW, clip_count(len - 8));
          end
          due.surge_word   = held[W_SURGE];
          due.sway_word    = held[W_SWAY];
          due.yaw_word     = held[W_YAW];
          due.length_field = frame_buf[POS_LEN];
          frames_due.push_back(due);
          drop_frame();
        end else begin
          // tail mismatch: byte stays in the body
          hunt = ST_BODY;
          advance = 1'b1;
        end
      end
    endcase
    if (advance) begin
      fill = fill + 1'b1;
      if (fill >= STORE_DEPTH) drop_frame();
    end
  endtask

  task automatic log_failure(input string what);
    fails++;
    if (fails <= 10) $display("%0t frame check: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t due;
    if (!rst_ni) begin
      sync_a = HEADER_FIRST_RST;
      sync_b = HEADER_SECOND_RST;
      end_a  = TAIL_FIRST_RST;
      end_b  = TAIL_SECOND_RST;
      foreach (held[k]) held[k] = '0;
      drop_frame();
      frames_due.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_HEADER_FIRST:  sync_a = cfg_data_i;
          REG_HEADER_SECOND: sync_b = cfg_data_i;
          REG_TAIL_FIRST:    end_a  = cfg_data_i;
          REG_TAIL_SECOND:   end_b  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) absorb_byte(rx_byte_i);
      if (out_valid_i && !out_stall_i) begin
        got.surge_word   = surge_word_i;
        got.sway_word    = sway_word_i;
        got.yaw_word     = yaw_word_i;
        got.length_field = length_field_i;
        got.command_ok   = command_ok_i;
        if (frames_due.size() == 0) begin
          log_failure($sformatf("unexpected result transfer: surge %h sway %h yaw %h len %h ok %b",
                                got.surge_word, got.sway_word, got.yaw_word,
                                got.length_field, got.command_ok));
        end else begin
          due = frames_due.pop_front();
          if (got.surge_word !== due.surge_word || got.sway_word !== due.sway_word ||
              got.yaw_word !== due.yaw_word || got.length_field !== due.length_field ||
              got.command_ok !== due.command_ok) begin
            log_failure($sformatf({"mismatch: exp surge %h sway %h yaw %h len %h ok %b",
                                   " / got surge %h sway %h yaw %h len %h ok %b"},
                                  due.surge_word, due.sway_word, due.yaw_word,
                                  due.length_field, due.command_ok,
                                  got.surge_word, got.sway_word, got.yaw_word,
                                  got.length_field, got.command_ok));
          end
        end
      end
    end
    pending_o    = frames_due.size();
    fail_count_o = fails;
  end

endmodule

// ----- verif/testbench.sv -----
// stimulus, clock, reset and verdict for the header/tail frame receiver
`timescale 1ns / 1ps

module testbench;

  import htfr_pkg::*;

  localparam int STORE_DEPTH   = 32;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES   = 380;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {
    RX_EAGER,
    RX_SPARSE,
    RX_CHOPPY,
    RX_BLOCKED
  } rx_pace_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_HEADER_FIRST;
  logic [7:0]           cfg_data = 8'h00;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [31:0]          surge_word;
  logic [31:0]          sway_word;
  logic [31:0]          yaw_word;
  logic [7:0]           length_field;
  logic                 command_ok;
  int                   pending;
  int                   fail_count;

  logic [7:0] hdr_a = HEADER_FIRST_RST;
  logic [7:0] hdr_b = HEADER_SECOND_RST;
  logic [7:0] end_a = TAIL_FIRST_RST;
  logic [7:0] end_b = TAIL_SECOND_RST;
  int         burst_left = 0;
  int         bytes_sent = 0;
  int         cycles = 0;
  rx_pace_e   pace = RX_EAGER;
  int         pace_left = 0;

  header_tail_frame_receiver #(
    .FRAME_DEPTH(STORE_DEPTH)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .surge_word_o   (surge_word),
    .sway_word_o    (sway_word),
    .yaw_word_o     (yaw_word),
    .length_field_o (length_field),
    .command_ok_o   (command_ok)
  );

  htfr_frame_checker #(
    .STORE_DEPTH(STORE_DEPTH)
  ) frame_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .surge_word_i   (surge_word),
    .sway_word_i    (sway_word),
    .yaw_word_i     (yaw_word),
    .length_field_i (length_field),
    .command_ok_i   (command_ok),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    if (pace_left == 0) begin
      pace      <= rx_pace_e'($urandom_range(0, 3));
      pace_left <= $urandom_range(20, 300);
    end else begin
      pace_left <= pace_left - 1;
    end
    case (pace)
      RX_EAGER:  out_stall <= 1'b0;
      RX_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      RX_CHOPPY: out_stall <= 1'($urandom_range(0, 1));
      default:   out_stall <= ((pace_left % 8) < 6);
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_frame(input int body_len, input bit tail_good);
    logic [7:0] b;
    send_byte(hdr_a);
    send_byte(hdr_b);
    for (int k = 0; k < body_len; k++) begin
      if (k == 0) begin
        b = $urandom_range(0, 1) ? 8'($urandom_range(0, 16)) : 8'($urandom);
      end else if (k == 1) begin
        b = ($urandom_range(0, 4) != 0) ? (8'($urandom) | MODE_MASK) : 8'($urandom);
      end else begin
        b = 8'($urandom);
      end
      send_byte(b);
    end
    send_byte(end_a);
    if (tail_good) begin
      send_byte(end_b);
    end else begin
      do b = 8'($urandom); while (b == end_b);
      send_byte(b);
    end
  endtask

  // wait for every expected result, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] h1, input logic [7:0] h2,
                            input logic [7:0] t1, input logic [7:0] t2);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_HEADER_FIRST;
    cfg_data <= h1;
    @(posedge clk);
    cfg_idx  <= REG_HEADER_SECOND;
    cfg_data <= h2;
    @(posedge clk);
    cfg_idx  <= REG_TAIL_FIRST;
    cfg_data <= t1;
    @(posedge clk);
    cfg_idx  <= REG_TAIL_SECOND;
    cfg_data <= t2;
    @(posedge clk);
    // unmapped index must leave every register alone
    cfg_idx  <= REG_UNUSED;
    cfg_data <= 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    hdr_a = h1;
    hdr_b = h2;
    end_a = t1;
    end_b = t2;
  endtask

  task automatic run_directed();
    logic [7:0] seq [$];
    seq = '{8'hFF, 8'h00,
            hdr_a, hdr_a, hdr_b,
            hdr_a, hdr_b, end_a, end_b,
            hdr_a, hdr_b, 8'd12, 8'hFF, 8'h00,
            8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
            8'h77, 8'h88, 8'h99, 8'hAA, 8'hBB, 8'hCC,
            end_a, end_b};
    foreach (seq[k]) send_byte(seq[k]);
    settle();
  endtask

  task automatic run_random(input int quota);
    int         stop_at;
    int         pick;
    logic [7:0] b;
    stop_at = bytes_sent + quota;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        send_frame($urandom_range(0, 28), 1'b1);
      end else if (pick < 76) begin
        send_frame($urandom_range(29, 40), 1'b1);
      end else if (pick < 86) begin
        send_frame($urandom_range(0, 20), 1'b0);
      end else if (pick < 93) begin
        send_byte(hdr_a);
        do b = 8'($urandom); while (b == hdr_b);
        send_byte(b);
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      end
    end
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(PHASE_BYTES);
    write_regs(8'h00, 8'hFF, 8'hFF, 8'h00);
    run_random(PHASE_BYTES);
    write_regs(8'hFF, 8'hFF, 8'h00, 8'h00);
    run_random(PHASE_BYTES);
    write_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_random(PHASE_BYTES);
    write_regs(HEADER_FIRST_RST, HEADER_SECOND_RST, TAIL_FIRST_RST, TAIL_SECOND_RST);
    run_random(PHASE_BYTES);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
